// ----- rtl/core/bcc_pkg.sv -----
// Shared types and constants of the button click classifier.
package bcc_pkg;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned NOW_BITS  = 32;
  localparam int unsigned CFG_BITS  = 16;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CLICK_MODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DOUBLE_WINDOW = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS    = 2'd2;

  localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd300;
  localparam logic [15:0] LONG_PRESS_RST    = 16'd1000;

  typedef logic [TIME_BITS-1:0] stamp_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } ev_kind_e;

  typedef struct packed {
    logic   is_down;
    stamp_t press_start;
    logic   long_done;
    stamp_t release_stamp;
    logic   short_pending;
    logic   second_click_armed;
  } click_state_t;

endpackage

// ----- rtl/core/bcc_if.sv -----
// Request and result channel interfaces of the button click classifier.
interface bcc_in_if;
  logic        valid;
  logic        ready;
  logic        press_edge;
  logic        release_edge;
  logic [31:0] now_ms;

  modport source (output valid, press_edge, release_edge, now_ms, input ready);
  modport sink   (input valid, press_edge, release_edge, now_ms, output ready);
endinterface

interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;

  modport source (output valid, event_kind, input ready);
  modport sink   (input valid, event_kind, output ready);
endinterface

// ----- rtl/core/button_click_classifier_top.sv -----
// Top level of the button click classifier: input register, classifier, result register.
//
// Each request (press edge, release edge, millisecond stamp) yields exactly one event:
// none, short press, long press or double click. A request is taken into an input
// register, classified against the stored button state and written to a result register,
// so the block takes one request per cycle while the result is not stalled; the state
// update on each request is the only loop. A stalled result holds the input register,
// which then takes no new request until the result register drains. The user must write
// configuration through the plain write port only while no request is in flight; the
// block itself does not enforce this.
module button_click_classifier_top
  import bcc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  bcc_in_if.sink                  in_i,
  bcc_out_if.source               out_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i
);

  logic        click_mode_q;
  logic [15:0] double_window_q;
  logic [15:0] long_press_q;

  logic         s1_valid_q;
  logic         s1_press_q;
  logic         s1_release_q;
  stamp_t       s1_now_q;
  logic         s1_adv;
  stamp_t       now_t;

  click_state_t st_q, st_d;
  ev_kind_e     ev_d;
  logic         out_valid_q;
  ev_kind_e     out_ev_q;

  generate
    if (TIME_BITS >= NOW_BITS) begin : g_now_ext
      assign now_t = stamp_t'(in_i.now_ms);
    end else begin : g_now_trunc
      assign now_t = in_i.now_ms[TIME_BITS-1:0];
    end
  endgenerate

  assign s1_adv      = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign out_o.valid = out_valid_q;
  assign out_o.event_kind = out_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_mode_q    <= 1'b0;
      double_window_q <= DOUBLE_WINDOW_RST;
      long_press_q    <= LONG_PRESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLICK_MODE:    click_mode_q    <= cfg_data_i[0];
        CFG_DOUBLE_WINDOW: double_window_q <= cfg_data_i[15:0];
        CFG_LONG_PRESS:    long_press_q    <= cfg_data_i[15:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_press_q   <= in_i.press_edge;
      s1_release_q <= in_i.release_edge;
      s1_now_q     <= now_t;
    end
  end

  always_comb begin
    stamp_t win;
    stamp_t lim;
    logic   done;
    win  = stamp_t'(double_window_q);
    lim  = stamp_t'(long_press_q);
    st_d = st_q;
    ev_d = EV_NONE;
    done = 1'b0;
    if (!click_mode_q) begin
      if (s1_press_q) begin
        if (st_d.short_pending && (stamp_t'(s1_now_q - st_d.release_stamp) <= win)) begin
          st_d.second_click_armed = 1'b1;
          st_d.short_pending      = 1'b0;
        end
        st_d.is_down     = 1'b1;
        st_d.press_start = s1_now_q;
        st_d.long_done   = 1'b0;
      end
      if (s1_release_q) begin
        st_d.is_down = 1'b0;
        if (!st_d.long_done) begin
          if (st_d.second_click_armed) begin
            st_d.second_click_armed = 1'b0;
            st_d.release_stamp      = '0;
            ev_d = EV_DOUBLE;
            done = 1'b1;
          end else begin
            st_d.short_pending = 1'b1;
            st_d.release_stamp = s1_now_q;
          end
        end else begin
          st_d.long_done          = 1'b0;
          st_d.short_pending      = 1'b0;
          st_d.second_click_armed = 1'b0;
          st_d.release_stamp      = '0;
        end
      end
      if (!done) begin
        if (st_d.short_pending && (stamp_t'(s1_now_q - st_d.release_stamp) > win)) begin
          st_d.short_pending = 1'b0;
          st_d.release_stamp = '0;
          ev_d = EV_SHORT;
        end else if (st_d.is_down && !st_d.long_done &&
                     (stamp_t'(s1_now_q - st_d.press_start) >= lim)) begin
          st_d.long_done          = 1'b1;
          st_d.short_pending      = 1'b0;
          st_d.second_click_armed = 1'b0;
          st_d.release_stamp      = '0;
          ev_d = EV_LONG;
        end
      end
    end else begin
      if (s1_press_q) begin
        st_d.is_down     = 1'b1;
        st_d.press_start = s1_now_q;
        st_d.long_done   = 1'b0;
      end
      if (s1_release_q) begin
        st_d.is_down = 1'b0;
        if (!st_d.long_done) begin
          ev_d = EV_SHORT;
          done = 1'b1;
        end
        st_d.long_done          = 1'b0;
        st_d.short_pending      = 1'b0;
        st_d.second_click_armed = 1'b0;
        st_d.release_stamp      = '0;
      end
      if (!done && st_d.is_down && !st_d.long_done &&
          (stamp_t'(s1_now_q - st_d.press_start) >= lim)) begin
        st_d.long_done = 1'b1;
        ev_d = EV_LONG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
      out_ev_q    <= EV_NONE;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        st_q     <= st_d;
        out_ev_q <= ev_d;
      end
    end
  end

  a_pend_arm_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.short_pending && st_q.second_click_armed))
    else $error("short press pending and second click armed together");

  a_long_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_valid_q && ev_d == EV_LONG && !click_mode_q)
    |=> (!st_q.short_pending && !st_q.second_click_armed && st_q.long_done))
    else $error("long press left click sequence state behind");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_now_q)))
    else $error("stalled request dropped from input register");

endmodule
